FILE: rtl/core/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, character codes and helper functions shared by the JSON string
// unescape decoder, its output buffer and its top level.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Decoder phase, one-hot
    typedef enum logic [6:0] {
        PH_IDLE    = 7'b000_0001,
        PH_BODY    = 7'b000_0010,
        PH_ESC     = 7'b000_0100,
        PH_HEX     = 7'b000_1000,
        PH_PAIR_BS = 7'b001_0000,
        PH_PAIR_U  = 7'b010_0000,
        PH_LOW_HEX = 7'b100_0000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    localparam logic [3:0] ERR_NO_QUOTE      = 4'd0;
    localparam logic [3:0] ERR_UNTERMINATED  = 4'd1;
    localparam logic [3:0] ERR_CONTROL_CHAR  = 4'd2;
    localparam logic [3:0] ERR_TRUNC_ESCAPE  = 4'd3;
    localparam logic [3:0] ERR_UNKNOWN_ESC   = 4'd4;
    localparam logic [3:0] ERR_TRUNC_U       = 4'd5;
    localparam logic [3:0] ERR_BAD_HEX       = 4'd6;
    localparam logic [3:0] ERR_LONE_HIGH     = 4'd7;
    localparam logic [3:0] ERR_BAD_LOW       = 4'd8;
    localparam logic [3:0] ERR_LONE_LOW      = 4'd9;
    localparam logic [3:0] ERR_NONE          = 4'd0;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    // Upper six bits of a 16-bit code unit for the surrogate ranges
    localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [3:0] err;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [CNT_W-1:0]          count;
    } batch_t;

    typedef struct packed {
        phase_t      phase;
        logic [1:0]  hex_count;
        logic [15:0] acc;
        logic [9:0]  high_bits;
    } state_t;

    typedef struct packed {
        logic             can_load;
        logic [CNT_W-1:0] pending;
    } buf_status_t;

    localparam result_t RESULT_ZERO = '{kind: KIND_BYTE, data: 8'h00, err: ERR_NONE};

    function automatic batch_t empty_batch();
        batch_t b;
        b.res   = {MAX_RESULTS{RESULT_ZERO}};
        b.count = '0;
        return b;
    endfunction

    function automatic batch_t one_result(kind_t kind, logic [7:0] data, logic [3:0] err);
        batch_t b;
        b = empty_batch();
        b.res[0].kind = kind;
        b.res[0].data = data;
        b.res[0].err  = err;
        b.count       = CNT_W'(1);
        return b;
    endfunction

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_value(logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
        return v;
    endfunction

    function automatic batch_t utf8_batch(logic [20:0] code);
        batch_t b;
        b = empty_batch();
        if (code <= 21'h7F) begin
            b.res[0].data = code[7:0];
            b.count       = CNT_W'(1);
        end
        else if (code <= 21'h7FF) begin
            b.res[0].data = {3'b110, code[10:6]};
            b.res[1].data = {2'b10, code[5:0]};
            b.count       = CNT_W'(2);
        end
        else if (code <= 21'hFFFF) begin
            b.res[0].data = {4'b1110, code[15:12]};
            b.res[1].data = {2'b10, code[11:6]};
            b.res[2].data = {2'b10, code[5:0]};
            b.count       = CNT_W'(3);
        end
        else begin
            b.res[0].data = {5'b11110, code[20:18]};
            b.res[1].data = {2'b10, code[17:12]};
            b.res[2].data = {2'b10, code[11:6]};
            b.res[3].data = {2'b10, code[5:0]};
            b.count       = CNT_W'(4);
        end
        return b;
    endfunction

endpackage

FILE: rtl/core/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streaming decoder for one quoted JSON string, byte in, decoded bytes out.
// ----------------------------------------------------------------------------
// Feed the raw text one byte per transaction, starting with the opening
// quote; a transaction with end_of_input set marks the end of the text.
// Plain bytes and simple escapes leave as one decoded byte, a \uXXXX escape
// as one to three UTF-8 bytes and a surrogate pair as four. The closing
// quote gives a done result, any fault one error result, and the decoder
// then waits for a new opening quote. Results appear in the cycle after the
// input byte is taken. The input takes one byte per cycle while in_stall is
// low; a byte that yields more than one result holds in_stall high while
// the four-entry result register drains, until the last of them leaves.
// last marks the final result caused by one input byte.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] result_kind,
    output logic [7:0] decoded_byte,
    output logic [3:0] error_code,
    output logic       last
);
    import jsu_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    batch_t      batch;
    result_t     head;
    buf_status_t status;
    logic        in_take;

    assign in_stall = !status.can_load;
    assign in_take  = in_valid && status.can_load;

    jsu_decode u_decode (
        .cur          (state_reg),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .nxt          (state_next),
        .batch        (batch)
    );

    jsu_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_take),
        .batch     (batch),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .head_last (last),
        .status    (status)
    );

    assign result_kind  = head.kind;
    assign decoded_byte = head.data;
    assign error_code   = head.err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{phase: PH_IDLE, hex_count: 2'd0, acc: 16'h0000,
                           high_bits: 10'h000};
        end
        else if (in_take)
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        status.pending <= CNT_W'(MAX_RESULTS))
        else $error("result register holds more than four results");

    a_stall_while_draining: assert property (@(posedge clk) disable iff (!rst_n)
        (status.pending > CNT_W'(1)) |-> in_stall)
        else $error("input taken while several results still pending");

    a_error_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && batch.count != '0 && batch.res[0].kind == KIND_ERR)
        |=> (state_reg.phase == PH_IDLE))
        else $error("decoder left running after an error result");

    a_batch_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && batch.count != '0) |=> (out_valid && status.pending == $past(batch.count)))
        else $error("result batch not loaded after input transaction");
`endif

endmodule

FILE: rtl/core/jsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Next-state and result logic for one raw byte of a quoted JSON string:
// escape handling, hex collection, surrogate pairing and UTF-8 encoding.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  jsu_pkg::state_t cur,
    input  logic [7:0]      data_byte,
    input  logic            end_of_input,
    output jsu_pkg::state_t nxt,
    output jsu_pkg::batch_t batch
);
    import jsu_pkg::*;

    logic [4:0]  digit;
    logic [15:0] acc_shift;

    assign digit     = hex_value(data_byte);
    assign acc_shift = {cur.acc[11:0], digit[3:0]};

    always_comb
    begin
        nxt   = cur;
        batch = empty_batch();
        case (cur.phase)
            PH_IDLE:
            begin
                if (end_of_input || data_byte != CH_QUOTE)
                begin
                    batch         = one_result(KIND_ERR, 8'h00, ERR_NO_QUOTE);
                    nxt.hex_count = 2'd0;
                end
                else
                begin
                    nxt.phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (end_of_input)
                begin
                    batch         = one_result(KIND_ERR, 8'h00, ERR_UNTERMINATED);
                    nxt.phase     = PH_IDLE;
                    nxt.hex_count = 2'd0;
                end
                else if (data_byte == CH_QUOTE)
                begin
                    batch     = one_result(KIND_DONE, 8'h00, ERR_NONE);
                    nxt.phase = PH_IDLE;
                end
                else if (data_byte < CH_SPACE)
                begin
                    batch         = one_result(KIND_ERR, 8'h00, ERR_CONTROL_CHAR);
                    nxt.phase     = PH_IDLE;
                    nxt.hex_count = 2'd0;
                end
                else if (data_byte == CH_BACKSLASH)
                begin
                    nxt.phase = PH_ESC;
                end
                else
                begin
                    batch = one_result(KIND_BYTE, data_byte, ERR_NONE);
                end
            end
            PH_ESC:
            begin
                nxt.phase = PH_BODY;
                if (end_of_input)
                begin
                    batch         = one_result(KIND_ERR, 8'h00, ERR_TRUNC_ESCAPE);
                    nxt.phase     = PH_IDLE;
                    nxt.hex_count = 2'd0;
                end
                else if (data_byte == CH_QUOTE || data_byte == CH_BACKSLASH
                         || data_byte == CH_SLASH)
                    batch = one_result(KIND_BYTE, data_byte, ERR_NONE);
                else if (data_byte == CH_B)
                    batch = one_result(KIND_BYTE, BYTE_BS, ERR_NONE);
                else if (data_byte == CH_F)
                    batch = one_result(KIND_BYTE, BYTE_FF, ERR_NONE);
                else if (data_byte == CH_N)
                    batch = one_result(KIND_BYTE, BYTE_LF, ERR_NONE);
                else if (data_byte == CH_R)
                    batch = one_result(KIND_BYTE, BYTE_CR, ERR_NONE);
                else if (data_byte == CH_T)
                    batch = one_result(KIND_BYTE, BYTE_TAB, ERR_NONE);
                else if (data_byte == CH_U)
                begin
                    nxt.phase     = PH_HEX;
                    nxt.hex_count = 2'd0;
                    nxt.acc       = 16'h0000;
                end
                else
                begin
                    batch         = one_result(KIND_ERR, 8'h00, ERR_UNKNOWN_ESC);
                    nxt.phase     = PH_IDLE;
                    nxt.hex_count = 2'd0;
                end
            end
            PH_HEX, PH_LOW_HEX:
            begin
                if (end_of_input || digit[4])
                begin
                    batch         = one_result(KIND_ERR, 8'h00,
                                               end_of_input ? ERR_TRUNC_U : ERR_BAD_HEX);
                    nxt.phase     = PH_IDLE;
                    nxt.hex_count = 2'd0;
                end
                else if (cur.hex_count != 2'd3)
                begin
                    nxt.acc       = acc_shift;
                    nxt.hex_count = cur.hex_count + 2'd1;
                end
                else
                begin
                    nxt.acc       = acc_shift;
                    nxt.hex_count = 2'd0;
                    if (cur.phase == PH_LOW_HEX)
                    begin
                        if (acc_shift[15:10] != SURR_LOW_TAG)
                        begin
                            batch     = one_result(KIND_ERR, 8'h00, ERR_BAD_LOW);
                            nxt.phase = PH_IDLE;
                        end
                        else
                        begin
                            // combine the pair: 0x10000 + (high << 10) + low offset
                            batch     = utf8_batch(SUPP_BASE +
                                                   {1'b0, cur.high_bits, acc_shift[9:0]});
                            nxt.phase = PH_BODY;
                        end
                    end
                    else if (acc_shift[15:10] == SURR_HIGH_TAG)
                    begin
                        nxt.high_bits = acc_shift[9:0];
                        nxt.phase     = PH_PAIR_BS;
                    end
                    else if (acc_shift[15:10] == SURR_LOW_TAG)
                    begin
                        batch     = one_result(KIND_ERR, 8'h00, ERR_LONE_LOW);
                        nxt.phase = PH_IDLE;
                    end
                    else
                    begin
                        batch     = utf8_batch({5'b0, acc_shift});
                        nxt.phase = PH_BODY;
                    end
                end
            end
            PH_PAIR_BS:
            begin
                if (end_of_input || data_byte != CH_BACKSLASH)
                begin
                    batch         = one_result(KIND_ERR, 8'h00, ERR_LONE_HIGH);
                    nxt.phase     = PH_IDLE;
                    nxt.hex_count = 2'd0;
                end
                else
                begin
                    nxt.phase = PH_PAIR_U;
                end
            end
            PH_PAIR_U:
            begin
                if (end_of_input || data_byte != CH_U)
                begin
                    batch         = one_result(KIND_ERR, 8'h00, ERR_LONE_HIGH);
                    nxt.phase     = PH_IDLE;
                    nxt.hex_count = 2'd0;
                end
                else
                begin
                    nxt.phase     = PH_LOW_HEX;
                    nxt.hex_count = 2'd0;
                    nxt.acc       = 16'h0000;
                end
            end
            default:
            begin
                nxt.phase     = PH_IDLE;
                nxt.hex_count = 2'd0;
            end
        endcase
    end

endmodule

FILE: rtl/core/jsu_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_outbuf
// Result register for up to four results of one input byte. Loads a whole
// batch at once and shifts one result out per output transaction.
// ----------------------------------------------------------------------------
module jsu_outbuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  jsu_pkg::batch_t      batch,
    input  logic                 out_stall,
    output logic                 out_valid,
    output jsu_pkg::result_t     head,
    output logic                 head_last,
    output jsu_pkg::buf_status_t status
);
    import jsu_pkg::*;

    result_t [MAX_RESULTS-1:0] entries_reg;
    result_t [MAX_RESULTS-1:0] entries_next;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic                      take;

    assign out_valid = (cnt_reg != '0);
    assign take      = out_valid && !out_stall;
    assign head      = entries_reg[0];
    assign head_last = (cnt_reg == CNT_W'(1));

    // a new batch fits when the register is empty or the last pending result leaves this cycle
    assign status.can_load = (cnt_reg == '0) || (head_last && !out_stall);
    assign status.pending  = cnt_reg;

    always_comb
    begin
        entries_next = entries_reg;
        cnt_next     = cnt_reg;
        if (load)
        begin
            entries_next = batch.res;
            cnt_next     = batch.count;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                entries_next[i] = entries_reg[i+1];
            end
            entries_next[MAX_RESULTS-1] = RESULT_ZERO;
            cnt_next                    = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

endmodule
